### rtl/lpm_pkg.sv
// Package: shared types, codes and helpers for the list prefix matcher.
package lpm_pkg;

   localparam int MaxLenDefault = 64;

   localparam logic [2:0] MODE_TEST   = 3'd0;
   localparam logic [2:0] MODE_STORE  = 3'd1;
   localparam logic [2:0] MODE_SINGLE = 3'd2;
   localparam logic [2:0] MODE_CLEAR  = 3'd3;
   localparam logic [2:0] MODE_DUMP   = 3'd4;

   localparam logic [1:0] KIND_INT = 2'd0;
   localparam logic [1:0] KIND_DBL = 2'd1;
   localparam logic [1:0] KIND_SYM = 2'd2;

   localparam logic [7:0] CHAR_HEX_MARK = 8'h68;
   localparam int         HexRadix      = 16;

   localparam int ElemWidth = 66;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_TEST = 4'b0010,
      ST_DUMP = 4'b0100,
      ST_SING = 4'b1000
   } state_type;

   // Fold kind code 3 onto the symbol kind.
   function automatic logic [1:0] norm_kind(input logic [1:0] k);
      norm_kind = (k[1]) ? KIND_SYM : k;
   endfunction

   function automatic logic [3:0] hex_digit(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) d = c - 8'h30;
      else if (c >= 8'h61 && c <= 8'h66) d = c - 8'h57;
      else if (c >= 8'h41 && c <= 8'h46) d = c - 8'h37;
      hex_digit = d[3:0];
   endfunction

   // IEEE equality on two doubles.
   function automatic logic dbl_eq(input logic [63:0] a, input logic [63:0] b);
      logic a_nan;
      logic b_nan;
      a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
      b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
      dbl_eq = !a_nan && !b_nan && ((a == b) || ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)));
   endfunction

   // Exact int32 to double conversion.
   function automatic logic [63:0] int_to_dbl(input logic [31:0] v);
      logic [31:0] mag;
      logic [5:0]  msb;
      logic [62:0] sh;
      mag = v[31] ? (~v + 32'd1) : v;
      msb = 6'd0;
      for (int i = 0; i < 32; i++) begin
         if (mag[i]) msb = 6'(i);
      end
      sh = 63'(mag) << (6'd52 - msb);
      if (mag == 32'd0) int_to_dbl = 64'd0;
      else int_to_dbl = {v[31], 11'(11'd1023 + 11'(msb)), sh[51:0]};
   endfunction

   // Truncate a double toward zero and saturate to int32 (NaN gives 0).
   function automatic logic [31:0] dbl_to_int(input logic [63:0] d);
      logic [10:0] e;
      logic [52:0] m;
      logic [52:0] t;
      logic [31:0] mag;
      e = d[62:52];
      m = {1'b1, d[51:0]};
      dbl_to_int = 32'd0;
      if (e == 11'h7FF && d[51:0] != 52'd0) dbl_to_int = 32'd0;
      else if (e >= 11'd1054) dbl_to_int = d[63] ? 32'h80000000 : 32'h7FFFFFFF;
      else if (e >= 11'd1023) begin
         t = m >> (11'd1075 - e);
         mag = t[31:0];
         dbl_to_int = d[63] ? (~mag + 32'd1) : mag;
      end
   endfunction

endpackage

### rtl/lpm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module lpm_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // Write and read, read data registered.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### rtl/list_prefix_matcher_top.sv
// Top level of the list prefix matcher.
// Usage:
//  Requests enter on req_ (tdata, tuser, tlast); verdicts and dumped pattern
//  elements leave on rsp_. A test element is read against the pattern memory;
//  the compare happens the cycle after the read. A single-number test reads,
//  then compares into the output register. A dump reads the first element,
//  then sends the stored elements in order, each send issuing the next read
//  on the memory's one read port. A verdict appears in the cycle after the
//  final test element reaches the compare stage.
//  Results go through one output register; while it is full and the
//  receiver stalls, the block holds its work and takes no request.
//  Reset empties the pattern (every test list then matches) and clears all
//  positions; the pattern memory keeps no reset value and needs no pass.
`default_nettype none
module list_prefix_matcher_top
   import lpm_pkg::*;
#(
   parameter int MaxLen = MaxLenDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tdata: elem_value[63:0], first_char[71:64], second_char[79:72],
   //        third_char[87:80]
   input  wire logic [87:0]  req_tdata,
   // tuser: mode[2:0], elem_kind[4:3]
   input  wire logic [4:0]   req_tuser,
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tdata: matched[0], out_kind[2:1], out_value[66:3], zero fill up to 71
   output logic [71:0]       rsp_tdata,
   // tuser: result_kind[0]
   output logic [0:0]        rsp_tuser,
   output logic              rsp_tlast
);
   localparam int AW = (MaxLen > 1) ? $clog2(MaxLen) : 1;
   localparam int CW = $clog2(MaxLen + 1);
   localparam logic [CW-1:0] MaxCnt = CW'(MaxLen);

   state_type state_ff, state_in;
   logic [CW-1:0] plen_ff, plen_in, spos_ff, spos_in, tpos_ff, tpos_in;
   logic          smatch_ff, smatch_in;
   logic [CW-1:0] dpos_ff, dpos_in;

   // test element held for compare
   logic [1:0]  tkind_ff, tkind_in;
   logic [63:0] tval_ff, tval_in;
   logic        tlast_ff, tlast_in, tcmp_ff, tcmp_in;

   logic        ov_ff, ov_in;
   logic        okind_ff, okind_in, omatch_ff, omatch_in, olast_ff, olast_in;
   logic [1:0]  otk_ff, otk_in;
   logic [63:0] oval_ff, oval_in;

   logic [2:0]  mode;
   logic [1:0]  kind;
   logic [63:0] val;
   logic [7:0]  c1, c2, c3;
   logic        acc;

   logic              wr_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [ElemWidth-1:0] wr_data, rd_data;
   logic [1:0]        pk;
   logic [63:0]       pv;
   logic              agree;
   logic              out_free;

   assign mode = req_tuser[2:0];
   assign kind = norm_kind(req_tuser[4:3]);
   assign c1 = req_tdata[71:64];
   assign c2 = req_tdata[79:72];
   assign c3 = req_tdata[87:80];
   assign val = (kind == KIND_INT) ? {{32{req_tdata[31]}}, req_tdata[31:0]} :
                (kind == KIND_SYM) ? {40'd0, c3, c2, c1} : req_tdata[63:0];

   assign out_free   = !ov_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign acc        = req_tvalid && req_tready;
   assign pk = rd_data[65:64];
   assign pv = rd_data[63:0];

   lpm_ram #(.Width(ElemWidth), .Depth(MaxLen)) u_pat (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Compare held test element with pattern entry.
   always_comb begin
      agree = 1'b1;
      if (tkind_ff == KIND_SYM || pk == KIND_SYM) agree = 1'b1;
      else if (tkind_ff == KIND_INT) begin
         if (pk == KIND_INT) agree = (tval_ff[31:0] == pv[31:0]);
         else agree = dbl_eq(int_to_dbl(tval_ff[31:0]), pv);
      end else begin
         if (pk == KIND_INT) agree = (dbl_to_int(tval_ff) == pv[31:0]);
         else agree = dbl_eq(tval_ff, pv);
      end
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      plen_in = plen_ff; spos_in = spos_ff; tpos_in = tpos_ff;
      smatch_in = smatch_ff; dpos_in = dpos_ff;
      tkind_in = tkind_ff; tval_in = tval_ff; tlast_in = tlast_ff; tcmp_in = tcmp_ff;
      ov_in = ov_ff && !rsp_tready;
      okind_in = okind_ff; omatch_in = omatch_ff; olast_in = olast_ff;
      otk_in = otk_ff; oval_in = oval_ff;
      wr_en = 1'b0; wr_addr = spos_ff[AW-1:0];
      wr_data = {KIND_INT, 64'd0};
      rd_addr = tpos_ff[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               tkind_in = kind; tval_in = val; tlast_in = req_tlast;
               case (mode)
                  MODE_TEST: begin
                     tcmp_in = (tpos_ff < MaxCnt) && (tpos_ff < plen_ff);
                     if (tpos_ff < MaxCnt) tpos_in = tpos_ff + CW'(1);
                     state_in = ST_TEST;
                  end
                  MODE_STORE: begin
                     if (spos_ff < MaxCnt) begin
                        wr_en = 1'b1;
                        if (kind == KIND_SYM && c3 == CHAR_HEX_MARK)
                           wr_data = {KIND_INT, 56'd0,
                                      8'(HexRadix) * 8'(hex_digit(c1)) + 8'(hex_digit(c2))};
                        else wr_data = {kind, val};
                        spos_in = spos_ff + CW'(1);
                     end
                     if (req_tlast) begin
                        plen_in = (spos_ff < MaxCnt) ? spos_ff + CW'(1) : spos_ff;
                        spos_in = '0;
                     end
                  end
                  MODE_SINGLE: begin
                     rd_addr = '0;
                     state_in = ST_SING;
                  end
                  MODE_CLEAR: begin
                     wr_en = 1'b1; wr_addr = '0;
                     plen_in = CW'(1); spos_in = '0; tpos_in = '0; smatch_in = 1'b1;
                  end
                  MODE_DUMP: begin
                     rd_addr = '0;
                     dpos_in = '0;
                     if (plen_ff != '0) state_in = ST_DUMP;
                  end
                  default: ;
               endcase
            end
         end
         ST_TEST: begin
            if (tcmp_ff && !agree) smatch_in = 1'b0;
            if (tlast_ff) begin
               ov_in = 1'b1; okind_in = 1'b0; otk_in = KIND_INT; oval_in = '0; olast_in = 1'b1;
               omatch_in = smatch_ff && !(tcmp_ff && !agree) && (tpos_ff >= plen_ff);
               tpos_in = '0; smatch_in = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_SING: begin
            ov_in = 1'b1; okind_in = 1'b0; otk_in = KIND_INT; oval_in = '0; olast_in = 1'b1;
            omatch_in = (plen_ff == CW'(1)) && (tkind_ff != KIND_SYM) && (pk == tkind_ff) &&
                        ((tkind_ff == KIND_INT) ? (tval_ff[31:0] == pv[31:0])
                                                : dbl_eq(tval_ff, pv));
            state_in = ST_IDLE;
         end
         ST_DUMP: begin
            rd_addr = dpos_ff[AW-1:0];
            if (out_free) begin
               ov_in = 1'b1; okind_in = 1'b1; omatch_in = 1'b0;
               otk_in = pk; oval_in = pv;
               olast_in = (dpos_ff + CW'(1) == plen_ff);
               dpos_in = dpos_ff + CW'(1);
               rd_addr = dpos_in[AW-1:0];
               if (olast_in) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         plen_ff <= '0; spos_ff <= '0; tpos_ff <= '0; smatch_ff <= 1'b1;
         dpos_ff <= '0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         plen_ff <= plen_in; spos_ff <= spos_in; tpos_ff <= tpos_in;
         smatch_ff <= smatch_in; dpos_ff <= dpos_in; ov_ff <= ov_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      tkind_ff <= tkind_in; tval_ff <= tval_in; tlast_ff <= tlast_in; tcmp_ff <= tcmp_in;
      okind_ff <= okind_in; omatch_ff <= omatch_in; olast_ff <= olast_in;
      otk_ff <= otk_in; oval_ff <= oval_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {5'd0, oval_ff, otk_ff, omatch_ff};
   assign rsp_tuser  = okind_ff;
   assign rsp_tlast  = olast_ff;
endmodule
`default_nettype wire

### rtl/lpm_checker.sv
// Port-level checker for the list prefix matcher, bound to the top level.
`default_nettype none
module lpm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [71:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser,
   input wire logic        rsp_tlast
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");
   a_verdict_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast)
      else $error("verdict without last");
   a_verdict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[71:1] == 71'd0)
      else $error("verdict carries payload");
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while response stalled");
   a_no_req_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");
endmodule
`default_nettype wire

bind list_prefix_matcher_top lpm_checker u_lpm_checker (.*);

### dv/list_prefix_matcher_top_test.sv
// Testbench for the list prefix matcher: directed table, over-long lists, then random lists checked by a predictor.
`default_nettype none
module list_prefix_matcher_top_test;
   import lpm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MaxLen = 64;

   typedef struct packed {
      logic [2:0]  mode;
      logic [1:0]  kind;
      logic [63:0] value;
      logic [7:0]  c1;
      logic [7:0]  c2;
      logic [7:0]  c3;
      logic        last;
   } request_type;

   typedef struct packed {
      logic        result_kind;
      logic        matched;
      logic [1:0]  out_kind;
      logic [63:0] out_value;
      logic        out_last;
   } response_type;

   // Directed row: request plus an optional typed-in verdict.
   typedef struct packed {
      request_type req;
      logic        has_verdict;
      logic        verdict;
   } row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [87:0]  req_tdata = '0;
   logic [4:0]   req_tuser = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [71:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         rsp_tlast;

   list_prefix_matcher_top #(.MaxLen(MaxLen)) i_dut (.*);

   always #5 clock = ~clock;

   // Predictor state.
   logic [1:0]  pat_kind [MaxLen];
   logic [63:0] pat_val  [MaxLen];
   int          pat_len;
   int          store_pos;
   int          test_pos;
   bit          still_ok;

   response_type expected_q[$];
   int          fail_count = 0;
   longint      cycle_count = 0;
   bit          rsp_random_stall = 1'b1;

   function automatic int as_int(logic [63:0] v);
      return $signed(v[31:0]);
   endfunction

   function automatic bit is_nan(logic [63:0] v);
      return v[62:52] == 11'h7FF && v[51:0] != 0;
   endfunction

   function automatic bit real_eq(logic [63:0] a, logic [63:0] b);
      if (is_nan(a) || is_nan(b)) return 1'b0;
      return $bitstoreal(a) == $bitstoreal(b);
   endfunction

   function automatic int trunc_to_int(logic [63:0] v);
      real d;
      d = $bitstoreal(v);
      if (is_nan(v)) return 0;
      if (d >= 2147483647.0) return 32'h7FFFFFFF;
      if (d <= -2147483648.0) return 32'h80000000;
      return $rtoi(d);
   endfunction

   function automatic int hex_val(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return 0;
   endfunction

   function automatic bit elem_agrees(logic [1:0] tk, logic [63:0] tv,
                                      logic [1:0] pk, logic [63:0] pv);
      if (tk == KIND_SYM || pk == KIND_SYM) return 1'b1;
      if (tk == KIND_INT) begin
         if (pk == KIND_INT) return as_int(tv) == as_int(pv);
         return real_eq($realtobits(real'(as_int(tv))), pv);
      end
      if (pk == KIND_INT) return trunc_to_int(tv) == as_int(pv);
      return real_eq(tv, pv);
   endfunction

   function automatic response_type verdict(bit m);
      response_type r;
      r = '0;
      r.matched = m;
      r.out_last = 1'b1;
      return r;
   endfunction

   // Advance the matcher model by one request and queue its results.
   task automatic predict_matcher(request_type rq);
      logic [1:0]   k;
      logic [63:0]  v;
      response_type r;
      bit           m;
      k = rq.kind[1] ? KIND_SYM : rq.kind;
      if (k == KIND_INT) v = 64'(as_int(rq.value));
      else if (k == KIND_SYM) v = {40'd0, rq.c3, rq.c2, rq.c1};
      else v = rq.value;
      case (rq.mode)
         MODE_TEST: begin
            if (test_pos < MaxLen) begin
               if (test_pos < pat_len &&
                   !elem_agrees(k, v, pat_kind[test_pos], pat_val[test_pos]))
                  still_ok = 1'b0;
               test_pos++;
            end
            if (rq.last) begin
               expected_q.push_back(verdict(still_ok && test_pos >= pat_len));
               test_pos = 0;
               still_ok = 1'b1;
            end
         end
         MODE_STORE: begin
            if (store_pos < MaxLen) begin
               if (k == KIND_SYM && rq.c3 == CHAR_HEX_MARK) begin
                  pat_kind[store_pos] = KIND_INT;
                  pat_val[store_pos] = 64'(hex_val(rq.c1) * HexRadix + hex_val(rq.c2));
               end else begin
                  pat_kind[store_pos] = k;
                  pat_val[store_pos] = v;
               end
               store_pos++;
            end
            if (rq.last) begin
               pat_len = store_pos;
               store_pos = 0;
            end
         end
         MODE_SINGLE: begin
            m = 1'b0;
            if (pat_len == 1 && k != KIND_SYM && pat_kind[0] == k)
               m = (k == KIND_INT) ? as_int(v) == as_int(pat_val[0])
                                   : real_eq(v, pat_val[0]);
            expected_q.push_back(verdict(m));
         end
         MODE_CLEAR: begin
            pat_kind[0] = KIND_INT;
            pat_val[0] = '0;
            pat_len = 1;
            store_pos = 0;
            test_pos = 0;
            still_ok = 1'b1;
         end
         MODE_DUMP: begin
            for (int i = 0; i < pat_len; i++) begin
               r = '0;
               r.result_kind = 1'b1;
               r.out_kind = pat_kind[i];
               r.out_value = pat_val[i];
               r.out_last = (i + 1 == pat_len);
               expected_q.push_back(r);
            end
         end
         default: ;
      endcase
   endtask

   function automatic int gap_len();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   // Drive one request and wait for its acceptance; drop valid only for a gap.
   task automatic send_request(request_type rq);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {rq.c3, rq.c2, rq.c1, rq.value};
      req_tuser  <= {rq.kind, rq.mode};
      req_tlast  <= rq.last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_matcher(rq);
      @(negedge clock);
   endtask

   function automatic request_type mk(logic [2:0] md, logic [1:0] k, logic [63:0] v,
                                      logic last, logic [7:0] a = 8'd0,
                                      logic [7:0] b = 8'd0, logic [7:0] c = 8'd0);
      request_type r;
      r.mode = md; r.kind = k; r.value = v; r.c1 = a; r.c2 = b; r.c3 = c; r.last = last;
      return r;
   endfunction

   // Random element value biased toward values that compare.
   function automatic logic [63:0] rand_value(logic [1:0] k);
      logic [63:0] v;
      int sel;
      sel = $urandom_range(0, 5);
      if (k == KIND_INT) begin
         case (sel)
            0: v = {$urandom, $urandom};
            1: v = 64'(32'sh7FFFFFFF);
            2: v = {32'hFFFFFFFF, 32'h80000000};
            default: v = 64'($signed(4'($urandom_range(0, 15))) );
         endcase
      end else begin
         case (sel)
            0: v = {$urandom, $urandom};
            1: v = 64'h7FF8000000000001;
            2: v = 64'h8000000000000000;
            3: v = $realtobits(real'($urandom_range(0, 6)) - 3.0);
            4: v = $realtobits(3.0e10);
            default: v = $realtobits(real'($urandom_range(0, 7)) * 0.5);
         endcase
      end
      return v;
   endfunction

   function automatic request_type rand_elem(logic [2:0] md, logic last);
      logic [1:0] k;
      logic [7:0] c3;
      k = 2'($urandom_range(0, 9) < 4 ? KIND_INT :
             ($urandom_range(0, 5) < 4 ? KIND_DBL : 2'($urandom_range(2, 3))));
      c3 = $urandom_range(0, 2) == 0 ? CHAR_HEX_MARK : 8'($urandom);
      return mk(md, k, rand_value(k), last, 8'($urandom), 8'($urandom), c3);
   endfunction

   task automatic send_list(logic [2:0] md, int len);
      for (int i = 0; i < len; i++) send_request(rand_elem(md, i == len - 1));
   endtask

   // Stop sending and wait until every expected result is back.
   task automatic drain_all();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Collect results and compare with the oldest expectation.
   always @(posedge clock) begin
      response_type got, exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.result_kind = rsp_tuser[0];
         got.matched     = rsp_tdata[0];
         got.out_kind    = rsp_tdata[2:1];
         got.out_value   = rsp_tdata[66:3];
         got.out_last    = rsp_tlast;
         if (expected_q.size() == 0) begin
            $error("unexpected response %p", got);
            fail_count++;
         end else begin
            exp_r = expected_q.pop_front();
            if (got.result_kind != exp_r.result_kind) begin
               $error("result_kind exp %0d got %0d", exp_r.result_kind, got.result_kind);
               fail_count++;
            end
            if (got.matched != exp_r.matched) begin
               $error("matched exp %0d got %0d", exp_r.matched, got.matched);
               fail_count++;
            end
            if (got.out_kind != exp_r.out_kind) begin
               $error("out_kind exp %0d got %0d", exp_r.out_kind, got.out_kind);
               fail_count++;
            end
            if (got.out_value != exp_r.out_value) begin
               $error("out_value exp %h got %h", exp_r.out_value, got.out_value);
               fail_count++;
            end
            if (got.out_last != exp_r.out_last) begin
               $error("out_last exp %0d got %0d", exp_r.out_last, got.out_last);
               fail_count++;
            end
         end
      end
   end

   // Stall the response side at random.
   initial begin
      int gap;
      forever begin
         @(negedge clock);
         gap = (rsp_random_stall && $urandom_range(0, 3) == 0) ? gap_len() : 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Guard against a hang.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 20000000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   row_type directed[] = '{
      // Empty pattern after reset: any list matches, single number does not.
      '{mk(MODE_TEST, KIND_INT, 64'd5, 1'b1), 1'b1, 1'b1},
      '{mk(MODE_SINGLE, KIND_INT, 64'd0, 1'b1), 1'b1, 1'b0},
      '{mk(MODE_DUMP, KIND_INT, 64'd0, 1'b1), 1'b0, 1'b0},
      // Clear gives one integer 0.
      '{mk(MODE_CLEAR, KIND_INT, 64'd0, 1'b1), 1'b0, 1'b0},
      '{mk(MODE_SINGLE, KIND_INT, 64'd0, 1'b1), 1'b1, 1'b1},
      '{mk(MODE_SINGLE, KIND_SYM, 64'd0, 1'b1), 1'b1, 1'b0},
      '{mk(MODE_SINGLE, KIND_DBL, 64'd0, 1'b1), 1'b1, 1'b0},
      '{mk(MODE_DUMP, KIND_INT, 64'd0, 1'b1), 1'b0, 1'b0},
      // Ignored modes.
      '{mk(3'd5, KIND_INT, '1, 1'b1), 1'b0, 1'b0},
      '{mk(3'd7, 2'd3, '1, 1'b1, 8'hFF, 8'hFF, 8'hFF), 1'b0, 1'b0},
      // Store int max, hex symbol, double, and a kind-3 symbol that is also a hex symbol.
      '{mk(MODE_STORE, KIND_INT, 64'h7FFFFFFF, 1'b0), 1'b0, 1'b0},
      '{mk(MODE_STORE, KIND_SYM, 64'd0, 1'b0, "f", "F", "h"), 1'b0, 1'b0},
      '{mk(MODE_STORE, KIND_DBL, 64'h8000000000000000, 1'b0), 1'b0, 1'b0},
      '{mk(MODE_STORE, 2'd3, '1, 1'b1, "z", "q", "h"), 1'b0, 1'b0},
      '{mk(MODE_DUMP, KIND_INT, 64'd0, 1'b1), 1'b0, 1'b0},
      // Cross-type and wildcard tests.
      '{mk(MODE_TEST, KIND_DBL, $realtobits(3.0e10), 1'b0), 1'b0, 1'b0},
      '{mk(MODE_TEST, KIND_INT, 64'd255, 1'b0), 1'b0, 1'b0},
      '{mk(MODE_TEST, KIND_INT, 64'd0, 1'b0), 1'b0, 1'b0},
      '{mk(MODE_TEST, KIND_SYM, 64'd0, 1'b1, "a", "b", "c"), 1'b0, 1'b0},
      // Too short, then NaN mismatch.
      '{mk(MODE_TEST, KIND_INT, 64'hFFFFFFFF_7FFFFFFF, 1'b1), 1'b1, 1'b0},
      '{mk(MODE_TEST, KIND_DBL, 64'h7FF8000000000000, 1'b1), 1'b0, 1'b0},
      // Clear abandons a partial store.
      '{mk(MODE_STORE, KIND_INT, 64'd9, 1'b0), 1'b0, 1'b0},
      '{mk(MODE_CLEAR, KIND_INT, 64'd0, 1'b0), 1'b0, 1'b0},
      '{mk(MODE_TEST, KIND_DBL, 64'h8000000000000000, 1'b1), 1'b1, 1'b1}
   };

   initial begin
      int n;
      for (int i = 0; i < MaxLen; i++) begin
         pat_kind[i] = KIND_INT;
         pat_val[i] = '0;
      end
      pat_len = 0; store_pos = 0; test_pos = 0; still_ok = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         if (directed[i].has_verdict) begin
            send_request(directed[i].req);
            if (expected_q.size() == 0 ||
                expected_q[$].matched != directed[i].verdict) begin
               $error("row %0d: matched exp %0d predicted differently", i,
                      directed[i].verdict);
               fail_count++;
            end
         end else begin
            send_request(directed[i].req);
         end
      end

      // Over-long store and test, then dump the full pattern.
      send_list(MODE_STORE, MaxLen + 3);
      send_list(MODE_TEST, MaxLen + 2);
      send_request(mk(MODE_DUMP, KIND_INT, 64'd0, 1'b1));

      // Sender holds off until everything is back, with receiver stalls.
      drain_all();
      rsp_random_stall = 1'b0;
      send_request(mk(MODE_DUMP, KIND_INT, 64'd0, 1'b1));
      drain_all();
      rsp_random_stall = 1'b1;

      // Random phase: mostly store and test lists with random content, mixed with other modes.
      n = 0;
      while (n < 300) begin
         case ($urandom_range(0, 19))
            0: begin send_request(rand_elem(MODE_CLEAR, 1'b1)); n++; end
            1: begin send_request(rand_elem(MODE_DUMP, 1'b1)); n++; end
            2: begin send_request(rand_elem(3'($urandom_range(5, 7)), 1'b1)); n++; end
            3, 4: begin send_request(rand_elem(MODE_SINGLE, 1'b1)); n++; end
            5, 6, 7: begin
               int len;
               len = $urandom_range(1, 6);
               send_list(MODE_STORE, len); n += len;
            end
            8: begin send_request(rand_elem(MODE_TEST, 1'b0)); n++; end
            default: begin
               int len;
               len = $urandom_range(1, 8);
               send_list(MODE_TEST, len); n += len;
            end
         endcase
      end

      drain_all();
      repeat (200) @(posedge clock);
      if (fail_count == 0 && expected_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
